// File: rtl/dpsc_pkg.sv
// ----------------------------------------------------------------------------
// dpsc_pkg
// Shared types and constants for the distinct palindromic subsequence counter.
// ----------------------------------------------------------------------------
package dpsc_pkg;

  // Width of one letter code and of one count.
  localparam int LETTER_W = 5;
  localparam int COUNT_W  = 30;

  // All counts are kept modulo this prime.
  localparam logic [COUNT_W-1:0] PRIME = 30'd1000000007;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_INIT,
    ST_B_RD,
    ST_B_WR,
    ST_CLR,
    ST_D_RD,
    ST_D_LD,
    ST_D_K,
    ST_D_W,
    ST_D_NEXT,
    ST_F_RD,
    ST_F_K,
    ST_F_NEXT,
    ST_DONE
  } state_t;

endpackage

// File: rtl/dpsc_ram.sv
// ----------------------------------------------------------------------------
// dpsc_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that updates only when a read is requested.
// ----------------------------------------------------------------------------
module dpsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/dpsc_mod_add.sv
// ----------------------------------------------------------------------------
// dpsc_mod_add
// Shared modular adder: adds two residues and folds the sum back below the
// prime with one compare and subtract.
// ----------------------------------------------------------------------------
module dpsc_mod_add (
  input  logic [dpsc_pkg::COUNT_W-1:0] a,
  input  logic [dpsc_pkg::COUNT_W-1:0] b,
  output logic [dpsc_pkg::COUNT_W-1:0] y
);

  logic [dpsc_pkg::COUNT_W:0] sum;
  logic [dpsc_pkg::COUNT_W:0] red;

  // Both inputs are below the prime, so one subtraction is enough.
  always_comb begin
    sum = {1'b0, a} + {1'b0, b};
    red = sum - {1'b0, dpsc_pkg::PRIME};
    y   = (sum >= {1'b0, dpsc_pkg::PRIME}) ? red[dpsc_pkg::COUNT_W-1:0]
                                          : sum[dpsc_pkg::COUNT_W-1:0];
  end

endmodule

// File: rtl/distinct_palindromic_subsequence_count_top.sv
// ----------------------------------------------------------------------------
// distinct_palindromic_subsequence_count_top
// Counts the distinct non-empty palindromic subsequences of a letter string,
// modulo 1000000007.
// ----------------------------------------------------------------------------
// Usage: letters arrive on the input channel (in_valid, in_stall, letter,
// last_letter), one transfer per cycle while loading. Letters past MAX_LEN
// are dropped and reported through truncated. The transfer that carries
// last_letter starts the computation; in_stall stays high until it ends.
// After the last letter the sequencer builds the next-occurrence tables,
// clears the count table, walks its cells (stepping through every letter
// for each nonzero cell) and forms the final sum, all paced by the one
// shared modular adder and the count-table RAM port.
// One result transfer follows each string on out_valid / out_stall. The
// result register holds while out_stall is high; a new string may load
// meanwhile, and its result waits until the register is free.
// Reset empties the string and clears out_valid; RAM contents are
// not cleared by reset, the count table is cleared before each walk.
// ----------------------------------------------------------------------------
module distinct_palindromic_subsequence_count_top #(
  parameter int MAX_LEN  = 64,
  parameter int ALPHABET = 26
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [dpsc_pkg::LETTER_W-1:0]         letter,
  input  logic                                  last_letter,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [dpsc_pkg::COUNT_W-1:0]          palindrome_count,
  output logic                                  truncated
);

  localparam int IW     = $clog2(MAX_LEN + 1);
  localparam int LAW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int KW     = $clog2(ALPHABET + 1);
  localparam int RW     = ALPHABET * IW;
  localparam int HAW    = 2 * IW;
  localparam int HDEPTH = 1 << HAW;
  localparam int CW     = dpsc_pkg::COUNT_W;

  dpsc_pkg::state_t state, state_next;

  logic [IW-1:0]  len;
  logic           ovf;
  logic           bwd;
  logic [IW-1:0]  pos;
  logic [IW-1:0]  i;
  logic [IW-1:0]  j;
  logic [KW-1:0]  k;
  logic [RW-1:0]  cur;
  logic [CW-1:0]  v;
  logic [CW-1:0]  total;
  logic           ok_r;
  logic [HAW-1:0] tgt;

  logic                          ls_we, ls_re;
  logic [LAW-1:0]                ls_waddr, ls_raddr;
  logic [dpsc_pkg::LETTER_W-1:0] ls_rdata;
  logic                          nf_we, nf_re, nb_we, nb_re;
  logic [IW-1:0]                 tb_waddr, nf_raddr, nb_raddr;
  logic [RW-1:0]                 tb_wdata, nf_rdata, nb_rdata;
  logic                          h_we, h_re;
  logic [HAW-1:0]                h_waddr, h_raddr;
  logic [CW-1:0]                 h_wdata, h_rdata;
  logic [CW-1:0]                 ma_a, ma_b, ma_y;

  logic           accept;
  logic           out_free;
  logic [IW-1:0]  pos_m1;
  logic [IW-1:0]  n_m1;
  logic [IW-1:0]  src;
  logic [RW-1:0]  new_row;
  logic [KW-1:0]  ksel;
  logic [IW-1:0]  ni, nj, nfk;
  logic           ok;
  logic           fcond;
  logic [IW:0]    ij_sum;

  assign accept   = (state == dpsc_pkg::ST_IDLE) && in_valid;
  assign in_stall = (state != dpsc_pkg::ST_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign pos_m1   = pos - IW'(1);
  assign n_m1     = len - IW'(1);
  assign ij_sum   = {1'b0, i} + {1'b0, j};

  // Forward tables read the string from its end, backward tables from its start.
  assign src = bwd ? (len - pos) : pos_m1;

  // Next row of a table: the letter at pos-1 now occurs first at pos-1.
  always_comb begin
    new_row = cur;
    for (int kk = 0; kk < ALPHABET; kk++) begin
      if (ls_rdata == dpsc_pkg::LETTER_W'(kk)) begin
        new_row[kk*IW +: IW] = pos_m1;
      end
    end
  end

  // Per-letter view of the table rows; the extra final step uses letter 0.
  always_comb begin
    ksel  = (k < KW'(ALPHABET)) ? k : '0;
    ni    = nf_rdata[ksel*IW +: IW];
    nj    = nb_rdata[ksel*IW +: IW];
    nfk   = ni;
    ok    = ({2'b0, ni} + {2'b0, nj} + (IW+2)'(2)) <= {2'b0, len};
    fcond = (k == KW'(ALPHABET)) || (({1'b0, nfk} + {1'b0, j} + (IW+1)'(1)) <= {1'b0, len});
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      dpsc_pkg::ST_IDLE: begin
        if (accept && last_letter) state_next = dpsc_pkg::ST_B_INIT;
      end
      dpsc_pkg::ST_B_INIT: begin
        state_next = (len == '0) ? dpsc_pkg::ST_CLR : dpsc_pkg::ST_B_RD;
      end
      dpsc_pkg::ST_B_RD: state_next = dpsc_pkg::ST_B_WR;
      dpsc_pkg::ST_B_WR: begin
        if (pos == IW'(1)) begin
          state_next = bwd ? dpsc_pkg::ST_CLR : dpsc_pkg::ST_B_INIT;
        end else begin
          state_next = dpsc_pkg::ST_B_RD;
        end
      end
      dpsc_pkg::ST_CLR: begin
        if (i == len && j == len) begin
          state_next = (len == '0) ? dpsc_pkg::ST_F_RD : dpsc_pkg::ST_D_RD;
        end
      end
      dpsc_pkg::ST_D_RD: state_next = dpsc_pkg::ST_D_LD;
      dpsc_pkg::ST_D_LD: begin
        state_next = (h_rdata == '0) ? dpsc_pkg::ST_D_NEXT : dpsc_pkg::ST_D_K;
      end
      dpsc_pkg::ST_D_K: state_next = dpsc_pkg::ST_D_W;
      dpsc_pkg::ST_D_W: begin
        state_next = (k == KW'(ALPHABET - 1)) ? dpsc_pkg::ST_D_NEXT : dpsc_pkg::ST_D_K;
      end
      dpsc_pkg::ST_D_NEXT: begin
        state_next = (i == n_m1 && j == n_m1) ? dpsc_pkg::ST_F_RD : dpsc_pkg::ST_D_RD;
      end
      dpsc_pkg::ST_F_RD: state_next = dpsc_pkg::ST_F_K;
      dpsc_pkg::ST_F_K: begin
        if (k == KW'(ALPHABET)) state_next = dpsc_pkg::ST_F_NEXT;
      end
      dpsc_pkg::ST_F_NEXT: begin
        if (ij_sum == {1'b0, len} && i == len) begin
          state_next = dpsc_pkg::ST_DONE;
        end else begin
          state_next = dpsc_pkg::ST_F_RD;
        end
      end
      dpsc_pkg::ST_DONE: begin
        if (out_free) state_next = dpsc_pkg::ST_IDLE;
      end
      default: state_next = dpsc_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and shared adder operands.
  always_comb begin
    ls_we    = accept && (len < IW'(MAX_LEN));
    ls_waddr = len[LAW-1:0];
    ls_re    = (state == dpsc_pkg::ST_B_RD);
    ls_raddr = src[LAW-1:0];

    tb_waddr = (state == dpsc_pkg::ST_B_INIT) ? len : pos_m1;
    tb_wdata = (state == dpsc_pkg::ST_B_INIT) ? {ALPHABET{len}} : new_row;
    nf_we    = !bwd && (state == dpsc_pkg::ST_B_INIT || state == dpsc_pkg::ST_B_WR);
    nb_we    = bwd && (state == dpsc_pkg::ST_B_INIT || state == dpsc_pkg::ST_B_WR);
    nf_re    = (state == dpsc_pkg::ST_D_RD) || (state == dpsc_pkg::ST_F_RD);
    nf_raddr = i;
    nb_re    = (state == dpsc_pkg::ST_D_RD);
    nb_raddr = j;

    h_we    = (state == dpsc_pkg::ST_CLR) || (state == dpsc_pkg::ST_D_W && ok_r);
    h_waddr = (state == dpsc_pkg::ST_CLR) ? {i, j} : tgt;
    h_wdata = ma_y;
    if (state == dpsc_pkg::ST_CLR) begin
      h_wdata = (i == '0 && j == '0) ? CW'(1) : '0;
    end
    h_re    = (state == dpsc_pkg::ST_D_RD) || (state == dpsc_pkg::ST_F_RD) ||
              (state == dpsc_pkg::ST_D_K && ok);
    h_raddr = (state == dpsc_pkg::ST_D_K) ? {ni + IW'(1), nj + IW'(1)} : {i, j};

    if (state == dpsc_pkg::ST_F_K) begin
      ma_a = total;
      ma_b = h_rdata;
    end else begin
      ma_a = h_rdata;
      ma_b = v;
    end
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dpsc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer counters and accumulators.
  always_ff @(posedge clk) begin
    if (rst) begin
      len       <= '0;
      ovf       <= 1'b0;
      bwd       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // A taken result frees the register unless a new one is loaded now.
      if (out_valid && !out_stall && state != dpsc_pkg::ST_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        dpsc_pkg::ST_IDLE: begin
          if (accept) begin
            if (len < IW'(MAX_LEN)) begin
              len <= len + IW'(1);
            end else begin
              ovf <= 1'b1;
            end
          end
          bwd <= 1'b0;
          i   <= '0;
          j   <= '0;
        end
        dpsc_pkg::ST_B_INIT: begin
          cur <= {ALPHABET{len}};
          pos <= len;
        end
        dpsc_pkg::ST_B_WR: begin
          cur <= new_row;
          pos <= pos_m1;
          if (pos == IW'(1)) bwd <= 1'b1;
        end
        dpsc_pkg::ST_CLR: begin
          total <= '0;
          if (j == len) begin
            j <= '0;
            i <= (i == len) ? '0 : i + IW'(1);
          end else begin
            j <= j + IW'(1);
          end
        end
        dpsc_pkg::ST_D_LD: begin
          v <= h_rdata;
          k <= '0;
        end
        dpsc_pkg::ST_D_K: begin
          ok_r <= ok;
          tgt  <= {ni + IW'(1), nj + IW'(1)};
        end
        dpsc_pkg::ST_D_W: begin
          k <= k + KW'(1);
        end
        dpsc_pkg::ST_D_NEXT: begin
          if (j == n_m1) begin
            j <= '0;
            i <= (i == n_m1) ? '0 : i + IW'(1);
          end else begin
            j <= j + IW'(1);
          end
        end
        dpsc_pkg::ST_F_RD: begin
          k <= '0;
        end
        dpsc_pkg::ST_F_K: begin
          if (fcond) total <= ma_y;
          k <= k + KW'(1);
        end
        dpsc_pkg::ST_F_NEXT: begin
          if (ij_sum == {1'b0, len}) begin
            j <= '0;
            i <= i + IW'(1);
          end else begin
            j <= j + IW'(1);
          end
        end
        dpsc_pkg::ST_DONE: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            palindrome_count <= (total == '0) ? (dpsc_pkg::PRIME - CW'(1))
                                              : (total - CW'(1));
            truncated        <= ovf;
            len              <= '0;
            ovf              <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Letter store.
  dpsc_ram #(.WIDTH(dpsc_pkg::LETTER_W), .DEPTH(MAX_LEN)) u_letters (
    .clk(clk), .we(ls_we), .waddr(ls_waddr), .wdata(letter),
    .re(ls_re), .raddr(ls_raddr), .rdata(ls_rdata)
  );

  // Next-occurrence rows for the string.
  dpsc_ram #(.WIDTH(RW), .DEPTH(MAX_LEN + 1)) u_next_fwd (
    .clk(clk), .we(nf_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .re(nf_re), .raddr(nf_raddr), .rdata(nf_rdata)
  );

  // Next-occurrence rows for the reversed string.
  dpsc_ram #(.WIDTH(RW), .DEPTH(MAX_LEN + 1)) u_next_bwd (
    .clk(clk), .we(nb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .re(nb_re), .raddr(nb_raddr), .rdata(nb_rdata)
  );

  // Count table of palindrome halves, addressed by row and column.
  dpsc_ram #(.WIDTH(CW), .DEPTH(HDEPTH)) u_halves (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .re(h_re), .raddr(h_raddr), .rdata(h_rdata)
  );

  // Shared modular adder for the walk and the final sum.
  dpsc_mod_add u_add (
    .a(ma_a), .b(ma_b), .y(ma_y)
  );

endmodule
